FILE: hw/rtl/rfps_pkg.sv
`timescale 1ns / 1ps
package rfps_pkg;

  typedef logic [15:0] chan_t;

  // fixed-width part of one word as it moves through the block
  typedef struct packed {
    logic        kind;
    logic [6:0]  idx;
    logic [16:0] wval;
    chan_t [3:0] ch;
  } item_fix_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [2:0]  count;
    logic        scale_all;
  } cfg_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;
  localparam logic [1:0] REG_SCALE  = 2'd3;

  localparam logic [12:0] RST_WIDTH  = 13'd256;
  localparam logic [12:0] RST_HEIGHT = 13'd256;
  localparam logic [2:0]  RST_COUNT  = 3'd4;
  localparam logic        RST_SCALE  = 1'b0;

  localparam logic [16:0] UNITY_WEIGHT = 17'h10000;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // clamp a dimension to the maximum, then halve it
  function automatic int unsigned half_dim(logic [12:0] d, int unsigned maxd);
    int unsigned v;
    v = (32'(d) > maxd) ? maxd : 32'(d);
    return v >> 1;
  endfunction

endpackage

FILE: hw/rtl/rfps_front.sv
`timescale 1ns / 1ps
module rfps_front import rfps_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [6:0]       weight_index,
  input  logic [16:0]      weight_value,
  input  logic [11:0]      pixel_x,
  input  logic [11:0]      pixel_y,
  input  chan_t            channel_a,
  input  chan_t            channel_b,
  input  chan_t            channel_c,
  input  chan_t            channel_d,
  input  cfg_t             cfg,
  input  logic             q_full,
  output logic             q_push,
  output item_fix_t        q_fix,
  output logic [((($clog2(MAX_DIM/2+1)) > 12) ? $clog2(MAX_DIM/2+1) : 12)-1:0] q_dx,
  output logic [((($clog2(MAX_DIM/2+1)) > 12) ? $clog2(MAX_DIM/2+1) : 12)-1:0] q_dy
);

  localparam int CXW = $clog2(MAX_DIM/2+1);
  localparam int DXW = (CXW > 12) ? CXW : 12;

  logic [DXW-1:0] cx, cy, px, py;

  assign cx = DXW'(half_dim(cfg.width, MAX_DIM));
  assign cy = DXW'(half_dim(cfg.height, MAX_DIM));
  assign px = DXW'(pixel_x);
  assign py = DXW'(pixel_y);

  assign q_dx = (px >= cx) ? (px - cx) : (cx - px);
  assign q_dy = (py >= cy) ? (py - cy) : (cy - py);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_fix.kind  = kind;
    q_fix.idx   = weight_index;
    q_fix.wval  = (weight_value > UNITY_WEIGHT) ? UNITY_WEIGHT : weight_value;
    q_fix.ch[0] = channel_a;
    q_fix.ch[1] = channel_b;
    q_fix.ch[2] = channel_c;
    q_fix.ch[3] = channel_d;
  end

endmodule

FILE: hw/rtl/rfps_queue.sv
`timescale 1ns / 1ps
module rfps_queue import rfps_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0]   mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   cnt;

  assign full  = (cnt == (QAW+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/rfps_back.sv
`timescale 1ns / 1ps
module rfps_back import rfps_pkg::*; #(
  parameter int BANDS   = 100,
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_empty,
  input  item_fix_t                  q_fix,
  input  logic [((($clog2(MAX_DIM/2+1)) > 12) ? $clog2(MAX_DIM/2+1) : 12)-1:0] q_dx,
  input  logic [((($clog2(MAX_DIM/2+1)) > 12) ? $clog2(MAX_DIM/2+1) : 12)-1:0] q_dy,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output chan_t                      out_a,
  output chan_t                      out_b,
  output chan_t                      out_c,
  output chan_t                      out_d,
  output logic [$clog2(BANDS+1)-1:0] band_used
);

  localparam int CXW  = $clog2(MAX_DIM/2+1);
  localparam int DXW  = (CXW > 12) ? CXW : 12;
  localparam int CW   = 2*CXW + 1;
  localparam int PW   = 2*DXW + 1;
  localparam int BBW  = $clog2(BANDS*BANDS+1);
  localparam int LW   = PW + BBW;
  localparam int KW   = $clog2(BANDS+1);
  localparam int IW   = $clog2(BANDS);
  localparam int SQW  = 2*KW;
  localparam int PRW  = SQW + CW;
  localparam int MW   = (PRW > LW) ? PRW : LW;
  localparam logic [BBW-1:0] BB = BBW'(BANDS*BANDS);

  typedef struct packed {
    logic            vld;
    item_fix_t       fix;
    logic [LW-1:0]   lhs;
    logic [KW-1:0]   res;
    logic [SQW-1:0]  sq;
  } stg_t;

  logic adv;
  assign adv   = !(out_valid && out_stall);
  assign q_pop = adv && !q_empty;

  // squared corner distance, follows the config registers
  logic [CXW-1:0]   cx, cy;
  logic [2*CXW-1:0] cx2, cy2;
  logic [CW-1:0]    corner2;

  assign cx  = CXW'(half_dim(cfg.width, MAX_DIM));
  assign cy  = CXW'(half_dim(cfg.height, MAX_DIM));
  assign cx2 = cx * cx;
  assign cy2 = cy * cy;

  always_ff @(posedge clk) begin
    corner2 <= CW'(cx2) + CW'(cy2);
  end

  // stage A: squares of the offsets
  logic             a_vld;
  item_fix_t        a_fix;
  logic [2*DXW-1:0] a_dx2, a_dy2;
  logic [PW-1:0]    a_p;
  logic [LW-1:0]    a_lhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_fix <= q_fix;
      a_dx2 <= q_dx * q_dx;
      a_dy2 <= q_dy * q_dy;
    end
  end

  assign a_p   = PW'(a_dx2) + PW'(a_dy2);
  assign a_lhs = a_p * BB;

  // band search, one bit of the band per stage, MSB first
  stg_t s [KW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s[0].vld <= 1'b0;
    end else if (adv) begin
      s[0].vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s[0].fix <= a_fix;
      s[0].lhs <= a_lhs;
      s[0].res <= '0;
      s[0].sq  <= '0;
    end
  end

  for (genvar i = 0; i < KW; i++) begin : g_step
    localparam int B = KW - 1 - i;
    logic [KW-1:0]  cand;
    logic [SQW-1:0] cand_sq;
    logic [PRW-1:0] prod;
    logic           take;

    assign cand    = s[i].res | (KW'(1) << B);
    // (res + 2^B)^2 with res zero below bit B+1
    assign cand_sq = s[i].sq + (SQW'(s[i].res) << (B+1)) + (SQW'(1) << (2*B));
    assign prod    = cand_sq * corner2;
    assign take    = (32'(cand) <= 32'(BANDS)) && (MW'(prod) <= MW'(s[i].lhs));

    always_ff @(posedge clk) begin
      if (rst) begin
        s[i+1].vld <= 1'b0;
      end else if (adv) begin
        s[i+1].vld <= s[i].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s[i+1].fix <= s[i].fix;
        s[i+1].lhs <= s[i].lhs;
        s[i+1].res <= take ? cand : s[i].res;
        s[i+1].sq  <= take ? cand_sq : s[i].sq;
      end
    end
  end

  // table stage: loads write here, pixels read here, in stream order
  logic [16:0]     wmem [BANDS];
  logic [BANDS-1:0] wvalid;
  logic            t_vld;
  item_fix_t       t_fix;
  logic [KW-1:0]   t_res;
  logic            t_hit;
  logic [16:0]     t_rd;
  stg_t            sl;
  logic            load_ok, band_ok;

  assign sl      = s[KW];
  assign load_ok = (32'(sl.fix.idx) < 32'(BANDS));
  assign band_ok = (32'(sl.res) < 32'(BANDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld  <= 1'b0;
      wvalid <= '0;
    end else if (adv) begin
      t_vld <= sl.vld;
      if (sl.vld && sl.fix.kind == KIND_LOAD && load_ok) begin
        wvalid[IW'(sl.fix.idx)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_fix <= sl.fix;
      t_res <= sl.res;
      if (sl.vld && sl.fix.kind == KIND_LOAD) begin
        if (load_ok) wmem[IW'(sl.fix.idx)] <= sl.fix.wval;
      end else begin
        t_rd <= wmem[sl.res[IW-1:0]];
      end
      t_hit <= band_ok && wvalid[sl.res[IW-1:0]];
    end
  end

  // scaling and output register
  logic [16:0] weight;
  logic [2:0]  count;
  chan_t       res_ch [4];

  assign weight = t_hit ? t_rd : '0;

  always_comb begin
    count = cfg.count;
    if (count == 3'd0) count = 3'd1;
    if (count > 3'd4)  count = 3'd4;
  end

  for (genvar j = 0; j < 4; j++) begin : g_ch
    logic [32:0] prod;
    logic [16:0] shr;
    assign prod = t_fix.ch[j] * weight;
    assign shr  = prod[32:16];
    always_comb begin
      if (3'(j) >= count) begin
        res_ch[j] = '0;
      end else if (cfg.scale_all || 3'(j) == count - 3'd1) begin
        res_ch[j] = shr[16] ? 16'hFFFF : shr[15:0];
      end else begin
        res_ch[j] = t_fix.ch[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t_vld && t_fix.kind == KIND_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_a     <= res_ch[0];
      out_b     <= res_ch[1];
      out_c     <= res_ch[2];
      out_d     <= res_ch[3];
      band_used <= t_res;
    end
  end

endmodule

FILE: hw/rtl/radial_falloff_pixel_scaler_core.sv
`timescale 1ns / 1ps
// Radial falloff pixel scaler.
// Input channel: in_valid/in_stall carry one word per cycle unless stalled.
// kind 0 writes a falloff table weight (saturated to 1.0, index at or past
// BANDS dropped), kind 1 is a pixel whose channels get scaled by the weight
// of its band. Output channel: out_valid/out_stall, one word for each pixel,
// none for table writes. band_used is the chosen band; BANDS means weight
// zero. Throughput is one word per cycle while the output is not stalled.
// Path from input accept to out_valid: queue, offset squares, search load,
// one stage per band bit of the search, table read, scaling.
// A four-word queue sits after the front end; in_stall rises only when it
// fills. With out_valid and out_stall high the back pipeline holds and the
// queue absorbs incoming words. Table writes and pixel reads share one
// pipeline stage, so each pixel sees every table write accepted before it.
// Config regs over APB at 0x0 width, 0x4 height, 0x8 channel count,
// 0xC scale-all; write them only while the block is idle.
// Reset: config to 256x256, 4 channels, alpha-only; table reads as zero.
module radial_falloff_pixel_scaler_core import rfps_pkg::*; #(
  parameter int BANDS   = 100,
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [6:0]                 weight_index,
  input  logic [16:0]                weight_value,
  input  logic [11:0]                pixel_x,
  input  logic [11:0]                pixel_y,
  input  logic [15:0]                channel_a,
  input  logic [15:0]                channel_b,
  input  logic [15:0]                channel_c,
  input  logic [15:0]                channel_d,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_a,
  output logic [15:0]                out_b,
  output logic [15:0]                out_c,
  output logic [15:0]                out_d,
  output logic [$clog2(BANDS+1)-1:0] band_used
);

  localparam int CXW = $clog2(MAX_DIM/2+1);
  localparam int DXW = (CXW > 12) ? CXW : 12;
  localparam int FW  = $bits(item_fix_t);
  localparam int QW  = FW + 2*DXW;

  cfg_t cfg;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width     <= RST_WIDTH;
      cfg.height    <= RST_HEIGHT;
      cfg.count     <= RST_COUNT;
      cfg.scale_all <= RST_SCALE;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg.width     <= pwdata[12:0];
        REG_HEIGHT: cfg.height    <= pwdata[12:0];
        REG_COUNT:  cfg.count     <= pwdata[2:0];
        REG_SCALE:  cfg.scale_all <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      REG_COUNT:  prdata = 32'(cfg.count);
      REG_SCALE:  prdata = 32'(cfg.scale_all);
      default:    prdata = '0;
    endcase
  end

  logic           q_full, q_push, q_empty, q_pop;
  item_fix_t      f_fix, b_fix;
  logic [DXW-1:0] f_dx, f_dy, b_dx, b_dy;
  logic [QW-1:0]  q_din, q_dout;

  rfps_front #(.MAX_DIM(MAX_DIM)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .weight_index (weight_index),
    .weight_value (weight_value),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .channel_a    (channel_a),
    .channel_b    (channel_b),
    .channel_c    (channel_c),
    .channel_d    (channel_d),
    .cfg          (cfg),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_fix        (f_fix),
    .q_dx         (f_dx),
    .q_dy         (f_dy)
  );

  assign q_din = {f_fix, f_dx, f_dy};

  rfps_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign b_fix = q_dout[QW-1 -: FW];
  assign b_dx  = q_dout[2*DXW-1 -: DXW];
  assign b_dy  = q_dout[DXW-1:0];

  rfps_back #(.BANDS(BANDS), .MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_fix     (b_fix),
    .q_dx      (b_dx),
    .q_dy      (b_dy),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_a     (out_a),
    .out_b     (out_b),
    .out_c     (out_c),
    .out_d     (out_d),
    .band_used (band_used)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rfps_pkg::*;

  localparam int BANDS = 100;
  localparam int MAX_DIM = 4096;
  localparam int LATENCY = 12;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [15:0] a, b, c, d;
    logic [6:0]  band;
  } pix_res_t;

  class falloff_scoreboard;
    logic [16:0] weights[BANDS];
    logic [12:0] width, height;
    logic [2:0]  count;
    logic        scale_all;
    pix_res_t    pending[$];
    int          errors;
    int          n_pix, n_load;

    function new();
      foreach (weights[i]) weights[i] = '0;
      width = RST_WIDTH; height = RST_HEIGHT; count = RST_COUNT; scale_all = RST_SCALE;
      errors = 0; n_pix = 0; n_load = 0;
    endfunction

    function void set_reg(logic [1:0] r, logic [31:0] v);
      case (r)
        REG_WIDTH:  width = v[12:0];
        REG_HEIGHT: height = v[12:0];
        REG_COUNT:  count = v[2:0];
        REG_SCALE:  scale_all = v[0];
        default: ;
      endcase
    endfunction

    function logic [6:0] band_of(longint unsigned px, longint unsigned py);
      longint unsigned cx, cy, c2, dx, dy, lhs;
      int k;
      cx = ((width > MAX_DIM) ? MAX_DIM : width) / 2;
      cy = ((height > MAX_DIM) ? MAX_DIM : height) / 2;
      c2 = cx * cx + cy * cy;
      dx = (px >= cx) ? px - cx : cx - px;
      dy = (py >= cy) ? py - cy : cy - py;
      lhs = BANDS * BANDS * (dx * dx + dy * dy);
      if (c2 == 0) return 7'(BANDS);
      for (k = 1; k <= BANDS; k++)
        if (k * k * c2 > lhs) return 7'(k - 1);
      return 7'(BANDS);
    endfunction

    function void note_word(logic knd, logic [6:0] idx, logic [16:0] wv,
                            logic [11:0] px, logic [11:0] py, logic [15:0] ch[4]);
      pix_res_t r;
      logic [15:0] o[4];
      longint unsigned w, p;
      int cnt;
      if (knd == KIND_LOAD) begin
        n_load++;
        if (idx < BANDS) weights[idx] = (wv > UNITY_WEIGHT) ? UNITY_WEIGHT : wv;
        return;
      end
      n_pix++;
      r.band = band_of(px, py);
      w = (r.band < BANDS) ? weights[r.band] : 0;
      cnt = (count == 0) ? 1 : (count > 4) ? 4 : count;
      for (int j = 0; j < 4; j++) begin
        if (j >= cnt) o[j] = '0;
        else if (scale_all || j == cnt - 1) begin
          p = (ch[j] * w) >> 16;
          o[j] = (p > 16'hFFFF) ? 16'hFFFF : p[15:0];
        end else o[j] = ch[j];
      end
      r.a = o[0]; r.b = o[1]; r.c = o[2]; r.d = o[3];
      pending.insert(pending.size(), r);
    endfunction

    function void check_word(logic [15:0] a, b, c, d, logic [6:0] band);
      pix_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e.a) begin $error("out_a exp %0d got %0d", e.a, a); errors++; end
      if (b !== e.b) begin $error("out_b exp %0d got %0d", e.b, b); errors++; end
      if (c !== e.c) begin $error("out_c exp %0d got %0d", e.c, c); errors++; end
      if (d !== e.d) begin $error("out_d exp %0d got %0d", e.d, d); errors++; end
      if (band !== e.band) begin
        $error("band_used exp %0d got %0d", e.band, band); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic kind = 0;
  logic [6:0] weight_index = '0;
  logic [16:0] weight_value = '0;
  logic [11:0] pixel_x = '0, pixel_y = '0;
  logic [15:0] channel_a = '0, channel_b = '0, channel_c = '0, channel_d = '0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_a, out_b, out_c, out_d;
  logic [6:0] band_used;

  int send_idle_pct = 0, stall_pct = 0;
  int wdog = 0;
  falloff_scoreboard sb = new();

  always #5 clk = ~clk;

  radial_falloff_pixel_scaler_core #(.BANDS(BANDS), .MAX_DIM(MAX_DIM)) u_dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(out_a, out_b, out_c, out_d, band_used);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog: no progress");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

  task automatic write_reg(logic [1:0] r, logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {r, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(r, v);
  endtask

  // one word; valid held until accepted
  task automatic send_word(logic knd, logic [6:0] idx, logic [16:0] wv,
                           logic [11:0] px, logic [11:0] py, logic [15:0] ch[4]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; kind <= knd; weight_index <= idx; weight_value <= wv;
    pixel_x <= px; pixel_y <= py;
    channel_a <= ch[0]; channel_b <= ch[1]; channel_c <= ch[2]; channel_d <= ch[3];
    do @(posedge clk); while (in_stall);
    sb.note_word(knd, idx, wv, px, py, ch);
    @(negedge clk);
  endtask

  task automatic send_load(logic [6:0] idx, logic [16:0] wv);
    logic [15:0] ch[4];
    foreach (ch[i]) ch[i] = 16'($urandom);
    send_word(KIND_LOAD, idx, wv, 12'($urandom), 12'($urandom), ch);
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    logic [15:0] ch[4];
    foreach (ch[i]) ch[i] = 16'($urandom);
    send_word(KIND_PIXEL, 7'($urandom), 17'($urandom), px, py, ch);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int w, h;
    w = sb.width; h = sb.height;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) begin
        if ($urandom_range(9) == 0) send_load(7'($urandom), 17'($urandom));
        else send_load(7'($urandom_range(BANDS - 1)), 17'($urandom_range(UNITY_WEIGHT)));
      end else if ($urandom_range(9) == 0) send_pixel(12'($urandom), 12'($urandom));
      else send_pixel(12'($urandom_range((w > 4096 ? 4096 : w) - 1)),
                      12'($urandom_range((h > 4096 ? 4096 : h) - 1)));
    end
  endtask

  initial begin
    logic [15:0] mx[4];
    int w_set[6] = '{256, 4096, 640, 1, 8191, 37};
    int h_set[6] = '{256, 4096, 480, 1, 3, 8191};
    mx = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset table, then loads with saturation and dropped index
    send_pixel(12'd128, 12'd128);
    for (int i = 0; i < BANDS; i++)
      send_load(7'(i), (i == 0) ? 17'h1FFFF : 17'(65536 - i * 600));
    send_load(7'd127, 17'h1FFFF);
    send_load(7'(BANDS), 17'd5);
    send_word(KIND_PIXEL, 7'd0, 17'd0, 12'd128, 12'd128, mx);
    send_word(KIND_PIXEL, 7'd0, 17'd0, 12'd0, 12'd0, mx);
    send_word(KIND_PIXEL, 7'd0, 17'd0, 12'd4095, 12'd4095, mx);
    send_word(KIND_PIXEL, 7'd0, 17'd0, 12'd255, 12'd0, mx);
    send_pixel(12'd0, 12'd0);
    drain();
    write_reg(REG_SCALE, 1);
    write_reg(REG_COUNT, 0);
    send_pixel(12'd10, 12'd200);
    send_pixel(12'd128, 12'd0);
    drain();
    write_reg(REG_COUNT, 7);
    send_pixel(12'd200, 12'd10);
    drain();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WIDTH, w_set[ph]);
      write_reg(REG_HEIGHT, h_set[ph]);
      write_reg(REG_COUNT, $urandom_range(7));
      write_reg(REG_SCALE, ph & 1);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 60; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 60; end
          default: begin send_idle_pct = 10; stall_pct = 10; end
        endcase
        random_phase(60);
      end
      send_idle_pct = 0; stall_pct = 0;
      drain();
    end

    $display("covered %0d table loads and %0d pixels across several register settings",
             sb.n_load, sb.n_pix);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
